[rtl/core/ozg_pkg.sv]
`default_nettype none
package ozg_pkg;
	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_CLEAR = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	localparam int ATAN_ENTRIES = 24;
	localparam logic signed [33:0] GAIN_Q30 = 34'sd652032875;
	localparam logic [33:0] MOVE_LONG_PAD = 34'd157286;
	localparam logic [33:0] MOVE_LAT_MAG = 34'd216269;
	// reciprocal of 6: floor(n/6) == (n * 43691) >> 18 only for small n, so use 2^40 scale
	localparam logic [40:0] RECIP6_Q40 = 41'd183251937963;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0: r = 32'd536870912;
			5'd1: r = 32'd316933406;
			5'd2: r = 32'd167458907;
			5'd3: r = 32'd85004756;
			5'd4: r = 32'd42667331;
			5'd5: r = 32'd21354465;
			5'd6: r = 32'd10679838;
			5'd7: r = 32'd5340245;
			5'd8: r = 32'd2670163;
			5'd9: r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] sat32(input logic signed [67:0] v);
		logic [31:0] r;
		if (v > 68'sd2147483647) r = 32'h7FFF_FFFF;
		else if (v < -68'sd2147483648) r = 32'h8000_0000;
		else r = v[31:0];
		return r;
	endfunction
endpackage
`default_nettype wire

[rtl/core/obstacle_zonotope_generator.sv]
// channel | dir | tdata fields (low bit up)                             | tuser
// s_axis  | in  | start_x, start_y, heading_angle, speed, body_length,  | kind
//         |     | body_width, is_static, query_index, time_low,time_high|
// m_axis  | out | center_x, center_y, long_gen_x, long_gen_y, lat_gen_x,| index_error
//         |     | lat_gen_y                                             |
// Load, clear and unused kinds leave the sequencer idle and can follow back to back.
// A query result is offered after these steps: read and angle prep, CORDIC one step a cycle,
// length and divide, then seven multiply/round slot pairs (six products, one idle) on one
// shared 34x34 multiplier. A bad index goes from the read state straight to the output.
// A result is held in the output state until m_tready.
// arst_n clears the entry count and the sequencer; the table is left as written.
`default_nettype none
module obstacle_zonotope_generator
	import ozg_pkg::*;
#(
	parameter int MAX_OBSTACLES = 32,
	parameter int CORDIC_STEPS = 16
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	// start_x[31:0] start_y[63:32] heading_angle[79:64] speed[103:80]
	// body_length[127:104] body_width[151:128] is_static[152] query_index[157:153]
	// time_low[181:158] time_high[205:182], zero to 208
	input  wire [207:0]  s_tdata,
	input  wire [1:0]    s_tuser,   // kind
	output logic         m_tvalid,
	input  wire          m_tready,
	// center_x center_y long_gen_x long_gen_y lat_gen_x lat_gen_y, 32 bits each
	output logic [191:0] m_tdata,
	output logic         m_tuser    // index_error
);
	localparam int IW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
	localparam int CW = $clog2(MAX_OBSTACLES + 1);

	localparam logic [3:0] ST_IDLE = 4'd0, ST_READ = 4'd1, ST_PREP = 4'd2,
		ST_CORD = 4'd3, ST_DIST = 4'd4, ST_MUL = 4'd5, ST_LEN = 4'd6,
		ST_DIV = 4'd7, ST_GEN = 4'd8, ST_OUT = 4'd9;

	logic [3:0] state_q;
	logic [CW-1:0] count_q;

	logic [31:0] mem_x [MAX_OBSTACLES];
	logic [31:0] mem_y [MAX_OBSTACLES];
	logic [15:0] mem_h [MAX_OBSTACLES];
	logic [23:0] mem_s [MAX_OBSTACLES];
	logic [23:0] mem_l [MAX_OBSTACLES];
	logic [23:0] mem_w [MAX_OBSTACLES];
	logic        mem_st [MAX_OBSTACLES];

	logic [31:0] rx_q, ry_q;
	logic [15:0] rh_q;
	logic [23:0] rs_q, rl_q, rw_q;
	logic        rst_q;
	logic [24:0] tsum_q;
	logic [23:0] dt_q;

	logic signed [33:0] cx_q, cy_q;
	logic signed [33:0] cz_q;
	logic        flip_q;
	logic [4:0]  step_q;
	logic [2:0]  mstep_q;
	logic signed [33:0] dist_q, lm_q, wm_q, len_q;
	logic signed [67:0] prod_q;
	logic [191:0] res_q;
	logic err_q;

	wire [4:0] qidx5 = s_tdata[157:153];
	wire [IW-1:0] qidx = IW'(qidx5);
	wire accept = s_tvalid && s_tready;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata = res_q;
	assign m_tuser = err_q;

	always_ff @(posedge clk) begin
		if (accept && s_tuser == KIND_LOAD && count_q < CW'(MAX_OBSTACLES)) begin
			mem_x[count_q[IW-1:0]] <= s_tdata[31:0];
			mem_y[count_q[IW-1:0]] <= s_tdata[63:32];
			mem_h[count_q[IW-1:0]] <= s_tdata[79:64];
			mem_s[count_q[IW-1:0]] <= s_tdata[103:80];
			mem_l[count_q[IW-1:0]] <= s_tdata[127:104];
			mem_w[count_q[IW-1:0]] <= s_tdata[151:128];
			mem_st[count_q[IW-1:0]] <= s_tdata[152];
		end
		if (accept) begin
			rx_q <= mem_x[qidx];
			ry_q <= mem_y[qidx];
			rh_q <= mem_h[qidx];
			rs_q <= mem_s[qidx];
			rl_q <= mem_l[qidx];
			rw_q <= mem_w[qidx];
			rst_q <= mem_st[qidx];
		end
	end

	// shared multiplier operands
	logic signed [33:0] ma;
	logic signed [33:0] mb;
	always_comb begin
		ma = lm_q;
		mb = cx_q;
		case (mstep_q)
			3'd0: begin ma = dist_q; mb = cx_q; end
			3'd1: begin ma = dist_q; mb = cy_q; end
			3'd2: begin ma = lm_q; mb = cx_q; end
			3'd3: begin ma = lm_q; mb = cy_q; end
			3'd4: begin ma = wm_q; mb = cy_q; end
			3'd5: begin ma = wm_q; mb = cx_q; end
			default: begin ma = lm_q; mb = cx_q; end
		endcase
	end

	logic signed [67:0] rnd;
	assign rnd = (prod_q + 68'sd536870912) >>> 30;

	logic signed [33:0] dxs, dys;
	assign dxs = cy_q >>> step_q;
	assign dys = cx_q >>> step_q;

	// fold the heading into the right half plane, negate the result later
	logic [15:0] ang_r;
	logic        flip_c;
	assign flip_c = ((rh_q + 16'h4000) & 16'h8000) != 16'h0;
	assign ang_r = flip_c ? rh_q - 16'h8000 : rh_q;

	// (5*len+3)/6 by the 2^40 reciprocal, exact for n below 2^37; split in two halves
	logic [36:0] n5;
	logic [59:0] qhi_q, qlo_q;
	logic [77:0] qsum;
	assign n5 = 37'(len_q) * 37'd5 + 37'd3;
	assign qsum = {qhi_q, 18'd0} + 78'(qlo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (accept) begin
					if (s_tuser == KIND_LOAD) begin
						if (count_q < CW'(MAX_OBSTACLES)) count_q <= count_q + 1'b1;
					end else if (s_tuser == KIND_CLEAR) begin
						count_q <= '0;
					end else if (s_tuser == KIND_QUERY) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= err_q ? ST_OUT : ST_PREP;
				ST_PREP: state_q <= ST_CORD;
				ST_CORD: if (32'(step_q) == CORDIC_STEPS - 1 ||
					32'(step_q) == ATAN_ENTRIES - 1) state_q <= ST_DIST;
				ST_DIST: state_q <= ST_LEN;
				ST_LEN: state_q <= ST_DIV;
				ST_DIV: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_GEN;
				ST_GEN: if (mstep_q == 3'd6) state_q <= ST_OUT;
				else state_q <= ST_MUL;
				ST_OUT: if (m_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				tsum_q <= 25'(s_tdata[181:158]) + 25'(s_tdata[205:182]);
				dt_q <= (s_tdata[205:182] > s_tdata[181:158]) ?
					s_tdata[205:182] - s_tdata[181:158] : 24'd0;
				err_q <= (32'(qidx5) >= 32'(count_q)) || (32'(qidx5) >= MAX_OBSTACLES);
				res_q <= '0;
			end
			ST_READ: ;
			ST_PREP: begin
				flip_q <= flip_c;
				cz_q <= 34'(signed'(ang_r)) <<< 16;
				cx_q <= GAIN_Q30;
				cy_q <= '0;
				step_q <= '0;
			end
			ST_CORD: begin
				if (!cz_q[33]) begin
					cx_q <= cx_q - dxs; cy_q <= cy_q + dys;
					cz_q <= cz_q - 34'(atan_turn(step_q));
				end else begin
					cx_q <= cx_q + dxs; cy_q <= cy_q - dys;
					cz_q <= cz_q + 34'(atan_turn(step_q));
				end
				step_q <= step_q + 1'b1;
			end
			ST_DIST: begin
				if (flip_q) begin cx_q <= -cx_q; cy_q <= -cy_q; end
				dist_q <= 34'(((50'(rs_q) * 50'(tsum_q)) + 50'h10000) >> 17);
				len_q <= 34'(rl_q) + 34'(((48'(rs_q) * 48'(dt_q)) + 48'h8000) >> 16);
			end
			ST_LEN: begin
				mstep_q <= '0;
				qhi_q <= 60'(n5[36:18]) * 60'(RECIP6_Q40);
				qlo_q <= 60'(n5[17:0]) * 60'(RECIP6_Q40);
			end
			ST_DIV: begin
				if (rst_q) begin
					lm_q <= (len_q + 34'sd1) >>> 1;
					wm_q <= 34'((25'(rw_q) + 25'd1) >> 1);
				end else begin
					lm_q <= 34'(qsum[77:40]) + MOVE_LONG_PAD;
					wm_q <= MOVE_LAT_MAG;
				end
			end
			ST_MUL: prod_q <= 68'(ma) * 68'(mb);
			ST_GEN: begin
				case (mstep_q)
					3'd0: res_q[31:0] <= sat32(68'(signed'(rx_q)) + rnd);
					3'd1: res_q[63:32] <= sat32(68'(signed'(ry_q)) + rnd);
					3'd2: res_q[95:64] <= sat32(rnd);
					3'd3: res_q[127:96] <= sat32(rnd);
					3'd4: res_q[159:128] <= sat32(-rnd);
					3'd5: res_q[191:160] <= sat32(rnd);
					default: ;
				endcase
				mstep_q <= mstep_q + 1'b1;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

[rtl/core/ozg_checker.sv]
`default_nettype none
module ozg_checker (
	input wire clk,
	input wire arst_n,
	input wire s_tvalid,
	input wire s_tready,
	input wire m_tvalid,
	input wire m_tready,
	input wire [191:0] m_tdata,
	input wire m_tuser
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("out hold");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("ready while result pending");
	a_err0: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0) else $error("error result not zero");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !m_tvalid) else $error("result too early");
endmodule
bind obstacle_zonotope_generator ozg_checker u_chk (.*);
`default_nettype wire
